### hw/rtl/ptc_pkg.sv
// Shared types and constants for the PID temperature controller.
package ptc_pkg;

    // Field widths
    localparam int TEMP_W   = 16;                 // Q8.8 temperature
    localparam int ERR_W    = 17;                 // measured minus setpoint
    localparam int INTEG_W  = 18;                 // saturated error sum
    localparam int DIFF_W   = 18;                 // last error minus error
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 12;
    localparam int FRAC_W   = 8;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W    = 37;

    // Limits
    localparam int INTEG_LIMIT   = 76800;          // 300.0 in Q8.8
    localparam int DRIVE_MAX     = 3000;
    localparam int DRIVE_LIMIT_Q = DRIVE_MAX * (1 << FRAC_W);

    // Register reset values
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST    = 16'd3000;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST   = 16'd4;
    localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST   = 16'd0;
    localparam logic signed [GAIN_W-1:0] DRIVE_OFFSET_RST = 16'sd0;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 2'd0,
        CFG_INTEG_GAIN   = 2'd1,
        CFG_DERIV_GAIN   = 2'd2,
        CFG_DRIVE_OFFSET = 2'd3
    } cfg_index_t;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [DRIVE_W-1:0]       drive_t;

endpackage

### hw/rtl/ptc_if.sv
// Valid/ready channel interfaces for samples and drive results.
interface ptc_sample_if;
    import ptc_pkg::*;

    logic  valid;
    logic  ready;
    temp_t setpoint;
    temp_t measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface ptc_result_if;
    import ptc_pkg::*;

    logic   valid;
    logic   ready;
    drive_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

### hw/rtl/pid_temperature_controller.sv
// PID temperature controller: error, saturating integral, gain products and drive clamp.
// The integral and last-error state update as a sample moves from stage 0 to stage 1.
// Throughput: one sample per cycle while result.ready does not stall the pipeline.
// Stages: input register, error/integral, three gain multipliers, sum and clamp.
// Reset (rst_n, asynchronous, active low) clears the integral, last error and all
// valid flags, and loads the gain and offset registers with their default values.
module pid_temperature_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data,
    ptc_sample_if.sink                        sample,
    ptc_result_if.source                      result
);
    import ptc_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0]        prop_gain_reg;
    logic [GAIN_W-1:0]        integ_gain_reg;
    logic [GAIN_W-1:0]        deriv_gain_reg;
    logic signed [GAIN_W-1:0] drive_offset_reg;

    // Controller state
    logic signed [INTEG_W-1:0] integral_sum_reg;
    logic signed [ERR_W-1:0]   last_error_reg;

    // Stage 0: captured sample
    logic  v0_reg;
    temp_t setpoint_reg;
    temp_t measured_reg;

    // Stage 1: error terms
    logic                      v1_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [DIFF_W-1:0]  diff_reg;

    // Stage 2: products
    logic                       v2_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;

    // Stage 3: result
    logic   v3_reg;
    drive_t drive_reg;

    // Stage advance enables
    logic adv0, adv1, adv2, adv3;
    logic xfer01;

    logic signed [ERR_W-1:0]   err_next;
    logic signed [INTEG_W:0]   integ_raw;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [ACC_W-1:0]   acc;
    drive_t                    drive_next;

    assign adv3   = !v3_reg || result.ready;
    assign adv2   = !v2_reg || adv3;
    assign adv1   = !v1_reg || adv2;
    assign adv0   = !v0_reg || adv1;
    assign xfer01 = v0_reg && adv1;

    assign sample.ready = adv0;
    assign result.valid = v3_reg;
    assign result.drive = drive_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= PROP_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            deriv_gain_reg   <= DERIV_GAIN_RST;
            drive_offset_reg <= DRIVE_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                CFG_DRIVE_OFFSET: drive_offset_reg <= $signed(cfg_data);
            endcase
        end
    end

    // Error, saturated integral and derivative difference
    always_comb
    begin
        err_next  = ERR_W'(measured_reg) - ERR_W'(setpoint_reg);
        integ_raw = (INTEG_W + 1)'(integral_sum_reg) + (INTEG_W + 1)'(err_next);
        priority if (integ_raw > (INTEG_W + 1)'(INTEG_LIMIT))
            integ_next = INTEG_W'(INTEG_LIMIT);
        else if (integ_raw < -(INTEG_W + 1)'(INTEG_LIMIT))
            integ_next = -INTEG_W'(INTEG_LIMIT);
        else
            integ_next = integ_raw[INTEG_W-1:0];
        diff_next = DIFF_W'(last_error_reg) - DIFF_W'(err_next);
    end

    // Sum of the terms, clamp and truncation to integer
    always_comb
    begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg)
            + (ACC_W'(drive_offset_reg) <<< FRAC_W);
        priority if (acc < 0)
            drive_next = '0;
        else if (acc > ACC_W'(DRIVE_LIMIT_Q))
            drive_next = DRIVE_W'(DRIVE_MAX);
        else
            drive_next = acc[FRAC_W +: DRIVE_W];
    end

    // Valid flags and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg           <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
        end
        else
        begin
            if (adv0)
                v0_reg <= sample.valid;
            if (adv1)
                v1_reg <= v0_reg;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (xfer01)
            begin
                integral_sum_reg <= integ_next;
                last_error_reg   <= err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv0 && sample.valid)
        begin
            setpoint_reg <= sample.setpoint;
            measured_reg <= sample.measured;
        end
        if (xfer01)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_next;
            diff_reg  <= diff_next;
        end
        if (v1_reg && adv2)
        begin
            prod_p_reg <= $signed({1'b0, prop_gain_reg}) * err_reg;
            prod_i_reg <= $signed({1'b0, integ_gain_reg}) * integ_reg;
            prod_d_reg <= $signed({1'b0, deriv_gain_reg}) * diff_reg;
        end
        if (v2_reg && adv3)
            drive_reg <= drive_next;
    end

    // Checks
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_sum_reg <= INTEG_W'(INTEG_LIMIT)) &&
        (integral_sum_reg >= -INTEG_W'(INTEG_LIMIT)))
        else $error("integral outside its saturation limits");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (drive_reg <= DRIVE_W'(DRIVE_MAX)))
        else $error("drive above its upper limit");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !xfer01 |=> ($stable(integral_sum_reg) && $stable(last_error_reg)))
        else $error("controller state changed without a sample moving on");

    a_state_track: assert property (@(posedge clk) disable iff (!rst_n)
        xfer01 |=> (last_error_reg == err_reg) && (integral_sum_reg == integ_reg) && v1_reg)
        else $error("stored state does not match the stage that left it");

endmodule
